// ===== rtl/rstu_pkg.sv =====
// shared types and constants for the ranked score table
package rstu_pkg;

  localparam int KEY_W   = 32;
  localparam int PTS_W   = 32;
  localparam int STAMP_W = 32;
  localparam int LABEL_W = 64;
  localparam int RANK_W  = 5;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_AWARD  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;
  // unused code, handled as a lookup
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTNEWER = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SORT,
    S_FIND,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic write_slot;
    logic sort_clr;
    logic sort_step;
    logic find_clr;
    logic find_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic do_write;
    logic sort_done;
    logic find_done;
  } stat_t;

endpackage

// ===== rtl/rstu_if.sv =====
// handshake channel interfaces for items and results
interface rstu_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [rstu_pkg::KEY_W-1:0]   player_key;
  logic [rstu_pkg::LABEL_W-1:0] player_label;
  logic signed [rstu_pkg::PTS_W-1:0] score_value;
  logic [rstu_pkg::STAMP_W-1:0] time_stamp;
  modport source (output valid, cmd, player_key, player_label, score_value, time_stamp,
                  input ready);
  modport sink (input valid, cmd, player_key, player_label, score_value, time_stamp,
                output ready);
endinterface

interface rstu_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [rstu_pkg::RANK_W-1:0]  entry_rank;
  logic signed [rstu_pkg::PTS_W-1:0] entry_points;
  logic [rstu_pkg::LABEL_W-1:0] entry_label;
  logic [rstu_pkg::RANK_W-1:0]  own_rank;
  logic signed [rstu_pkg::PTS_W-1:0] own_points;
  modport source (output valid, status, entry_rank, entry_points, entry_label, own_rank,
                  own_points, input ready);
  modport sink (input valid, status, entry_rank, entry_points, entry_label, own_rank,
                own_points, output ready);
endinterface

// ===== rtl/rstu_ctrl.sv =====
// sequencer for scan, write, sort and result phases
module rstu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic [1:0]      cmd_in,
  output rstu_pkg::cmd_t  cmd,
  input  rstu_pkg::stat_t stat
);
  rstu_pkg::state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rstu_pkg::S_IDLE;
      cmd_r       <= rstu_pkg::CMD_LOOKUP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      rstu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          cmd_nxt      = cmd_in;
          state_nxt    = rstu_pkg::S_SCAN;
        end
      end
      rstu_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = rstu_pkg::S_DECIDE;
      end
      rstu_pkg::S_DECIDE: begin
        cmd.sort_clr = 1'b1;
        cmd.find_clr = 1'b1;
        if ((cmd_r == rstu_pkg::CMD_SET || cmd_r == rstu_pkg::CMD_AWARD) && stat.do_write)
        begin
          cmd.write_slot = 1'b1;
          state_nxt      = rstu_pkg::S_SORT;
        end else begin
          state_nxt = rstu_pkg::S_FIND;
        end
      end
      rstu_pkg::S_SORT: begin
        cmd.sort_step = 1'b1;
        if (stat.sort_done) state_nxt = rstu_pkg::S_FIND;
      end
      rstu_pkg::S_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.find_done) state_nxt = rstu_pkg::S_OUT;
      end
      rstu_pkg::S_OUT: begin
        // wait for the previous result to drain
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rstu_pkg::S_IDLE;
        end
      end
      default: state_nxt = rstu_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == rstu_pkg::S_IDLE) else $error("load outside idle");
  a_outload: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("result not raised");
  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_slot |=> state_r == rstu_pkg::S_SORT) else $error("write without sort");
endmodule

// ===== rtl/rstu_dp.sv =====
// table registers, scan, compare-exchange sort and result registers
module rstu_dp #(
  parameter int TABLE_ENTRIES = 16,
  parameter int LABEL_BYTES   = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rstu_pkg::cmd_t  cmd,
  output rstu_pkg::stat_t stat,
  input  logic [rstu_pkg::KEY_W-1:0]   own_id,
  input  logic [1:0]                   in_cmd,
  input  logic [rstu_pkg::KEY_W-1:0]   in_key,
  input  logic [rstu_pkg::LABEL_W-1:0] in_label,
  input  logic signed [rstu_pkg::PTS_W-1:0] in_val,
  input  logic [rstu_pkg::STAMP_W-1:0] in_stamp,
  output logic [1:0]                   o_status,
  output logic [rstu_pkg::RANK_W-1:0]  o_rank,
  output logic signed [rstu_pkg::PTS_W-1:0] o_points,
  output logic [rstu_pkg::LABEL_W-1:0] o_label,
  output logic [rstu_pkg::RANK_W-1:0]  o_own_rank,
  output logic signed [rstu_pkg::PTS_W-1:0] o_own_points
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = rstu_pkg::KEY_W;
  localparam int PW = rstu_pkg::PTS_W;
  localparam int TW = rstu_pkg::STAMP_W;
  localparam int LW = rstu_pkg::LABEL_W;

  logic [KW-1:0] key_r [TABLE_ENTRIES];
  logic [LW-1:0] lab_r [TABLE_ENTRIES];
  logic signed [PW-1:0] pts_r [TABLE_ENTRIES];
  logic [TW-1:0] stp_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;

  logic [1:0]    icmd_r;
  logic [KW-1:0] ikey_r;
  logic [LW-1:0] ilab_r;
  logic signed [PW-1:0] ival_r;
  logic [TW-1:0] istp_r;

  logic [CW-1:0] sc_r;
  logic hit_r, emp_r;
  logic [IW-1:0] hit_idx_r, emp_idx_r;
  logic [1:0] st_r;
  logic [IW-1:0] si_r, sj_r;
  logic [CW-1:0] fc_r;
  logic ehit_r, ohit_r;
  logic [IW-1:0] eidx_r, oidx_r;

  logic [LW-1:0] clean;
  logic stop;
  always_comb begin
    clean = '0;
    stop  = 1'b0;
    for (int b = 0; b < LABEL_BYTES; b++) begin
      if (in_label[8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) clean[8*b +: 8] = in_label[8*b +: 8];
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_v
    assign vld[g] = lab_r[g][7:0] != 8'd0;
  end

  // saturating award add
  logic signed [PW:0] sum;
  logic signed [PW-1:0] newpts;
  logic [IW-1:0] sidx;
  logic newer;
  always_comb begin
    sum = {hit_r ? pts_r[hit_idx_r][PW-1] : 1'b0, hit_r ? pts_r[hit_idx_r] : '0}
          + {ival_r[PW-1], ival_r};
    if (icmd_r != rstu_pkg::CMD_AWARD) newpts = ival_r;
    else if (sum[PW] != sum[PW-1]) newpts = sum[PW] ? {1'b1, {(PW-1){1'b0}}}
                                                     : {1'b0, {(PW-1){1'b1}}};
    else newpts = sum[PW-1:0];
    sidx  = hit_r ? hit_idx_r : emp_idx_r;
    newer = (newpts > pts_r[hit_idx_r]) || (istp_r > stp_r[hit_idx_r]);
  end

  logic [IW-1:0] scan_i;
  assign scan_i = sc_r[IW-1:0];
  logic do_swap;
  assign do_swap = vld[sj_r] && (!vld[si_r] || pts_r[sj_r] > pts_r[si_r]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      icmd_r <= in_cmd;
      ikey_r <= in_key;
      ilab_r <= clean;
      ival_r <= in_val;
      istp_r <= in_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0; hit_r <= 1'b0; emp_r <= 1'b0;
      si_r <= '0; sj_r <= '0; fc_r <= '0; ehit_r <= 1'b0; ohit_r <= 1'b0;
      for (int k = 0; k < TABLE_ENTRIES; k++) lab_r[k] <= '0;
    end else begin
      if (cmd.scan_clr) begin
        sc_r <= '0; hit_r <= 1'b0; emp_r <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_done) begin
        sc_r <= sc_r + CW'(1);
        if (vld[scan_i] && key_r[scan_i] == ikey_r && !hit_r) begin
          hit_r <= 1'b1; hit_idx_r <= scan_i;
        end
        if (!vld[scan_i] && !emp_r) begin
          emp_r <= 1'b1; emp_idx_r <= scan_i;
        end
      end
      if (cmd.write_slot) begin
        key_r[sidx] <= ikey_r;
        lab_r[sidx] <= ilab_r;
        pts_r[sidx] <= newpts;
        stp_r[sidx] <= istp_r;
      end
      if (cmd.sort_clr) begin
        si_r <= '0; sj_r <= IW'(1);
      end else if (cmd.sort_step) begin
        if (do_swap) begin
          key_r[si_r] <= key_r[sj_r]; key_r[sj_r] <= key_r[si_r];
          lab_r[si_r] <= lab_r[sj_r]; lab_r[sj_r] <= lab_r[si_r];
          pts_r[si_r] <= pts_r[sj_r]; pts_r[sj_r] <= pts_r[si_r];
          stp_r[si_r] <= stp_r[sj_r]; stp_r[sj_r] <= stp_r[si_r];
        end
        if (sj_r == IW'(TABLE_ENTRIES - 1)) begin
          si_r <= si_r + IW'(1); sj_r <= si_r + IW'(2);
        end else sj_r <= sj_r + IW'(1);
      end
      if (cmd.find_clr) begin
        fc_r <= '0; ehit_r <= 1'b0; ohit_r <= 1'b0;
      end else if (cmd.find_step && !stat.find_done) begin
        fc_r <= fc_r + CW'(1);
        if (vld[fc_r[IW-1:0]] && key_r[fc_r[IW-1:0]] == ikey_r && !ehit_r) begin
          ehit_r <= 1'b1; eidx_r <= fc_r[IW-1:0];
        end
        if (vld[fc_r[IW-1:0]] && key_r[fc_r[IW-1:0]] == own_id && !ohit_r) begin
          ohit_r <= 1'b1; oidx_r <= fc_r[IW-1:0];
        end
      end
    end
  end

  // status decided at the decide step
  always_ff @(posedge clk) begin
    if (cmd.sort_clr) begin
      if (icmd_r == rstu_pkg::CMD_SET || icmd_r == rstu_pkg::CMD_AWARD) begin
        if (!hit_r && !emp_r) st_r <= rstu_pkg::ST_FULL;
        else if (hit_r && !newer) st_r <= rstu_pkg::ST_NOTNEWER;
        else st_r <= rstu_pkg::ST_OK;
      end else st_r <= hit_r ? rstu_pkg::ST_OK : rstu_pkg::ST_NOTFOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status     <= st_r;
      o_rank       <= ehit_r ? RANK_W_CAST(eidx_r) : '0;
      o_points     <= ehit_r ? pts_r[eidx_r] : '0;
      o_label      <= ehit_r ? lab_r[eidx_r] : '0;
      o_own_rank   <= ohit_r ? RANK_W_CAST(oidx_r) : '0;
      o_own_points <= ohit_r ? pts_r[oidx_r] : '0;
    end
  end

  function automatic logic [rstu_pkg::RANK_W-1:0] RANK_W_CAST(input logic [IW-1:0] i);
    logic [7:0] w;
    w = 8'(i) + 8'd1;
    return w[rstu_pkg::RANK_W-1:0];
  endfunction

  assign stat.scan_done = sc_r == CW'(TABLE_ENTRIES);
  assign stat.do_write  = (hit_r && newer) || (!hit_r && emp_r);
  assign stat.sort_done = cmd.sort_step && si_r == IW'(TABLE_ENTRIES - 2)
                          && sj_r == IW'(TABLE_ENTRIES - 1);
  assign stat.find_done = fc_r == CW'(TABLE_ENTRIES);

  a_sort_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sort_step |-> si_r < sj_r) else $error("sort indices out of order");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= CW'(TABLE_ENTRIES)) else $error("scan overran");
  a_find_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(TABLE_ENTRIES)) else $error("find overran");
endmodule

// ===== rtl/ranked_score_table_upsert_top.sv =====
// top level of the ranked score table
// One item at a time: accepted in the idle state, then a key scan over the TABLE_ENTRIES slots,
// a decide step, an exchange sort over every slot pair with a single compare-exchange unit
// (only after a write), a result scan and an output step. Results wait in an output register
// while the next item is taken once the table work is done; the output step stalls while the
// previous result is still unread.
module ranked_score_table_upsert_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int LABEL_BYTES   = 8
) (
  input  logic clk,
  input  logic rst_n,
  rstu_in_if.sink    in_ch,
  rstu_out_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [rstu_pkg::KEY_W-1:0]    cfg_wdata
);
  rstu_pkg::cmd_t  cmd;
  rstu_pkg::stat_t stat;
  logic [rstu_pkg::KEY_W-1:0] own_r;

  always_ff @(posedge clk) begin
    if (!rst_n) own_r <= '0;
    else if (cfg_we) own_r <= cfg_wdata;
  end

  rstu_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd_in   (in_ch.cmd), .cmd, .stat
  );

  rstu_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .LABEL_BYTES(LABEL_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .own_id   (own_r),
    .in_cmd   (in_ch.cmd), .in_key(in_ch.player_key), .in_label(in_ch.player_label),
    .in_val   (in_ch.score_value), .in_stamp(in_ch.time_stamp),
    .o_status (out_ch.status), .o_rank(out_ch.entry_rank),
    .o_points (out_ch.entry_points), .o_label(out_ch.entry_label),
    .o_own_rank(out_ch.own_rank), .o_own_points(out_ch.own_points)
  );
endmodule

// ===== tb/sv/tb_ranked_score_table_upsert_top.sv =====
// testbench for the ranked score table: directed table plus random upserts against a predictor
module tb_ranked_score_table_upsert_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rstu_pkg::*;

  localparam int SLOTS = 16;
  localparam int LBYTES = 8;
  localparam int PHASE_ITEMS = 500;
  localparam int SETTLE_CYCLES = 250;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [LABEL_W-1:0] label;
    logic signed [PTS_W-1:0] score;
    logic [STAMP_W-1:0] stamp;
  } update_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RANK_W-1:0]  rank;
    logic signed [PTS_W-1:0] points;
    logic [LABEL_W-1:0] label;
    logic [RANK_W-1:0]  own_rank;
    logic signed [PTS_W-1:0] own_points;
  } standing_t;

  typedef struct {
    update_t   upd;
    bit        typed;
    standing_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [KEY_W-1:0] cfg_wdata = '0;

  rstu_in_if  in_ch();
  rstu_out_if out_ch();

  ranked_score_table_upsert_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor copy of the table
  logic [KEY_W-1:0]        tbl_key   [SLOTS];
  logic [LABEL_W-1:0]      tbl_label [SLOTS];
  logic signed [PTS_W-1:0] tbl_pts   [SLOTS];
  logic [STAMP_W-1:0]      tbl_stamp [SLOTS];
  logic [KEY_W-1:0]        own_id;

  standing_t standings_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  function automatic bit occupied(int i);
    return tbl_label[i][7:0] != 8'd0;
  endfunction

  function automatic int slot_of(logic [KEY_W-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (occupied(i) && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [LABEL_W-1:0] trim_label(logic [LABEL_W-1:0] raw);
    logic [LABEL_W-1:0] res;
    res = '0;
    for (int i = 0; i < LBYTES; i++) begin
      if (raw[8*i +: 8] == 8'd0) break;
      res[8*i +: 8] = raw[8*i +: 8];
    end
    return res;
  endfunction

  function automatic logic [1:0] upsert(logic [KEY_W-1:0] k, logic [LABEL_W-1:0] lb,
                                        logic signed [PTS_W-1:0] p, logic [STAMP_W-1:0] st);
    int idx;
    logic [KEY_W-1:0] tk;
    logic [LABEL_W-1:0] tl;
    logic signed [PTS_W-1:0] tp;
    logic [STAMP_W-1:0] ts;
    idx = slot_of(k);
    if (idx < 0) begin
      for (int i = 0; i < SLOTS; i++)
        if (!occupied(i)) begin
          idx = i;
          break;
        end
      if (idx < 0) return ST_FULL;
    end else if (!(p > tbl_pts[idx]) && !(st > tbl_stamp[idx])) begin
      return ST_NOTNEWER;
    end
    tbl_key[idx] = k;
    tbl_label[idx] = lb;
    tbl_pts[idx] = p;
    tbl_stamp[idx] = st;
    for (int i = 0; i < SLOTS - 1; i++)
      for (int j = i + 1; j < SLOTS; j++)
        if (occupied(j) && (!occupied(i) || tbl_pts[j] > tbl_pts[i])) begin
          tk = tbl_key[i]; tl = tbl_label[i]; tp = tbl_pts[i]; ts = tbl_stamp[i];
          tbl_key[i] = tbl_key[j]; tbl_label[i] = tbl_label[j];
          tbl_pts[i] = tbl_pts[j]; tbl_stamp[i] = tbl_stamp[j];
          tbl_key[j] = tk; tbl_label[j] = tl; tbl_pts[j] = tp; tbl_stamp[j] = ts;
        end
    return ST_OK;
  endfunction

  function automatic standing_t apply_update(update_t u);
    standing_t r;
    logic [LABEL_W-1:0] lb;
    longint sum;
    int f;
    lb = trim_label(u.label);
    r = '0;
    if (u.cmd == CMD_SET) begin
      r.status = upsert(u.key, lb, u.score, u.stamp);
    end else if (u.cmd == CMD_AWARD) begin
      f = slot_of(u.key);
      sum = longint'(u.score) + (f >= 0 ? longint'(tbl_pts[f]) : 0);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      r.status = upsert(u.key, lb, PTS_W'(sum), u.stamp);
    end else begin
      r.status = slot_of(u.key) >= 0 ? ST_OK : ST_NOTFOUND;
    end
    f = slot_of(u.key);
    if (f >= 0) begin
      r.rank = RANK_W'(f + 1);
      r.points = tbl_pts[f];
      r.label = tbl_label[f];
    end
    f = slot_of(own_id);
    if (f >= 0) begin
      r.own_rank = RANK_W'(f + 1);
      r.own_points = tbl_pts[f];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // sender: drops valid only when it idles, so valid never toggles within one step
  task automatic offer(update_t u, standing_t want, bit typed);
    standing_t p;
    if (idle_on && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= u.cmd;
    in_ch.player_key <= u.key;
    in_ch.player_label <= u.label;
    in_ch.score_value <= u.score;
    in_ch.time_stamp <= u.stamp;
    p = apply_update(u);
    standings_q.push_back(typed ? want : p);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // receiver
  always @(posedge clk) begin
    standing_t w;
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (standings_q.size() == 0) begin
          report_mismatch("unexpected item", {62'd0, out_ch.status}, 64'd0);
        end else begin
          w = standings_q.pop_front();
          if (out_ch.status !== w.status)
            report_mismatch("status", 64'(out_ch.status), 64'(w.status));
          if (out_ch.entry_rank !== w.rank)
            report_mismatch("entry_rank", 64'(out_ch.entry_rank), 64'(w.rank));
          if (out_ch.entry_points !== w.points)
            report_mismatch("entry_points", 64'(out_ch.entry_points), 64'(w.points));
          if (out_ch.entry_label !== w.label)
            report_mismatch("entry_label", out_ch.entry_label, w.label);
          if (out_ch.own_rank !== w.own_rank)
            report_mismatch("own_rank", 64'(out_ch.own_rank), 64'(w.own_rank));
          if (out_ch.own_points !== w.own_points)
            report_mismatch("own_points", 64'(out_ch.own_points), 64'(w.own_points));
        end
      end
      out_ch.ready <= (hold_cycles > 1) ? 1'b0 : (!idle_on || $urandom_range(99) >= 28);
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    int n;
    n = $urandom_range(99);
    if (n < 5) return '1;
    if (n < 10) return '0;
    if (n < 88) return KEY_W'($urandom_range(22, 1));
    return $urandom;
  endfunction

  function automatic update_t random_update();
    update_t u;
    int n;
    n = $urandom_range(99);
    u.cmd = n < 40 ? CMD_SET : n < 70 ? CMD_AWARD : n < 95 ? CMD_LOOKUP : CMD_SPARE;
    u.key = pick_key();
    u.label = {$urandom, $urandom};
    n = $urandom_range(99);
    if (n < 8) u.label[7:0] = 8'd0;
    else if (n < 30) u.label[8*$urandom_range(7, 1) +: 8] = 8'd0;
    n = $urandom_range(99);
    if (n < 5) u.score = 32'sh7fffffff;
    else if (n < 10) u.score = 32'sh80000000;
    else if (n < 45) u.score = $signed(32'($urandom_range(200))) - 100;
    else u.score = $urandom;
    n = $urandom_range(99);
    u.stamp = n < 5 ? '1 : n < 40 ? STAMP_W'($urandom_range(50)) : $urandom;
    return u;
  endfunction

  task automatic settle_and_config(logic [KEY_W-1:0] id);
    while (standings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_id = id;
  endtask

  row_t rows[$];

  function automatic row_t mk(logic [1:0] c, logic [KEY_W-1:0] k, logic [LABEL_W-1:0] lb,
                              logic signed [PTS_W-1:0] s, logic [STAMP_W-1:0] st,
                              bit typed = 1'b0, standing_t want = '0);
    row_t r;
    r.upd = '{cmd: c, key: k, label: lb, score: s, stamp: st};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    logic [KEY_W-1:0] own_choice [4];
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOOKUP;
    in_ch.player_key = '0;
    in_ch.player_label = '0;
    in_ch.score_value = '0;
    in_ch.time_stamp = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0; tbl_label[i] = '0; tbl_pts[i] = '0; tbl_stamp[i] = '0;
    end
    own_id = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fresh table: lookup misses everywhere
    rows.push_back(mk(CMD_LOOKUP, 32'd5, 64'd0, 0, 0, 1'b1,
                      '{ST_NOTFOUND, 5'd0, 32'sd0, 64'd0, 5'd0, 32'sd0}));
    rows.push_back(mk(CMD_SET, 32'd5, 64'h41, 32'sh7fffffff, 32'd1, 1'b1,
                      '{ST_OK, 5'd1, 32'sh7fffffff, 64'h41, 5'd0, 32'sd0}));
    // award on a maxed entry saturates high
    rows.push_back(mk(CMD_AWARD, 32'd5, 64'h41, 32'sd1, 32'd2, 1'b1,
                      '{ST_OK, 5'd1, 32'sh7fffffff, 64'h41, 5'd0, 32'sd0}));
    rows.push_back(mk(CMD_SET, 32'hffffffff, 64'hffffffffffffffff, 32'sh80000000, 32'hffffffff));
    rows.push_back(mk(CMD_AWARD, 32'hffffffff, 64'h4242, -32'sd5, 32'd3));
    rows.push_back(mk(CMD_AWARD, 32'd0, 64'h0043004300430043, 32'sh80000000, 32'd0));
    rows.push_back(mk(CMD_SET, 32'd9, 64'h44, 32'sd10, 32'd10));
    rows.push_back(mk(CMD_SET, 32'd9, 64'h45, 32'sd10, 32'd10));
    rows.push_back(mk(CMD_SET, 32'd9, 64'h45, 32'sd9, 32'd11));
    rows.push_back(mk(CMD_SET, 32'd10, 64'h46, 32'sd10, 32'd1));
    rows.push_back(mk(CMD_SET, 32'd11, 64'h47, 32'sd10, 32'd1));
    rows.push_back(mk(CMD_SPARE, 32'd10, 64'd0, 0, 0));
    rows.push_back(mk(CMD_LOOKUP, 32'd11, 64'd0, 0, 0));
    // empty label drops the key
    rows.push_back(mk(CMD_SET, 32'd9, 64'hff00, 32'sd50, 32'd50));
    rows.push_back(mk(CMD_LOOKUP, 32'd9, 64'd0, 0, 0));
    rows.push_back(mk(CMD_AWARD, 32'd12, 64'h55aa33cc_77ee1199, 32'sd7, 32'd0));
    for (int k = 0; k < 8; k++)
      rows.push_back(mk(CMD_SET, 32'd100 + k, 64'h30 + k, $signed(32'(k)) - 3, 32'd4));
    rows.push_back(mk(CMD_SET, 32'd200, 64'h61, 32'sd1, 32'd1));
    foreach (rows[i]) offer(rows[i].upd, rows[i].want, rows[i].typed);

    own_choice[0] = 32'hffffffff;
    own_choice[1] = 32'd5;
    own_choice[2] = 32'd0;
    own_choice[3] = $urandom_range(22, 1);
    for (int ph = 0; ph < 4; ph++) begin
      in_ch.valid <= 1'b0;
      settle_and_config(own_choice[ph]);
      // long receiver hold so the block backs up
      if (ph == 1) hold_cycles = 3000;
      idle_on = (ph != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) offer(random_update(), '0, 1'b0);
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;
    while (standings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
